/* rtl/dfatm_pkg.sv */
package dfatm_pkg;

    // Item commands
    typedef enum logic [1:0] {
        CMD_WR_TRANS = 2'd0,
        CMD_WR_FLAG  = 2'd1,
        CMD_TEXT     = 2'd2,
        CMD_END      = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_INITIAL_STATE = 1'b0,
        CFG_STATE_COUNT   = 1'b1
    } t_cfg_idx;

    localparam int STATE_W = 8;
    localparam int SYM_W   = 8;
    localparam int COUNT_W = 9;
    localparam int ENTRY_W = STATE_W + 1;

    // Input request
    typedef struct packed {
        t_cmd                 command;
        logic [STATE_W-1:0]   state_index;
        logic [SYM_W-1:0]     symbol;
        logic [STATE_W-1:0]   next_state;
        logic                 next_valid;
        logic                 accept_flag;
    } t_in_req;

    // Result
    typedef struct packed {
        logic accepted;
        logic died;
    } t_out_res;

endpackage

/* rtl/dfatm_ram.sv */
module dfatm_ram #(
    parameter  int WIDTH = 9,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/dfa_table_matcher_unit.sv */
// Text bytes and load requests: one accepted per cycle, back to back, unless both result stages are full and stalled.
// End-of-text result: the flag read and dead bit pass the first result stage, then the output register.
// Throughput is set by the transition table lookup, whose registered read
// data feeds the next byte's table address directly.
// Reset (synchronous, active low) clears the walk state, config registers and result valid flags;
// transition table and accepting flags are undefined until loaded.
module dfa_table_matcher_unit #(
    parameter int NUM_STATES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input requests
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  dfatm_pkg::t_in_req        i_in_req,
    // results
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output dfatm_pkg::t_out_res       o_out_res,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  dfatm_pkg::t_cfg_idx       i_cfg_index,
    input  logic [8:0]                i_cfg_data
);

    import dfatm_pkg::*;

    localparam int TABLE_STATES = (NUM_STATES < 256) ? NUM_STATES : 256;
    localparam int SW           = $clog2(TABLE_STATES);
    localparam int TBL_DEPTH    = TABLE_STATES * (2 ** SYM_W);

    // Config registers
    logic [STATE_W-1:0] r_init;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] w_limit;

    // Walk state
    logic [STATE_W-1:0] r_cur,  n_cur;
    logic               r_dead, n_dead;
    logic               r_in_text, n_in_text;
    logic               r_lk,   n_lk;

    // Result pipeline
    logic               r_s1_v,    n_s1_v;
    logic               r_s1_dead, n_s1_dead;
    logic               r_out_v,   n_out_v;
    t_out_res           r_out,     n_out;

    // Memory ports
    logic [ENTRY_W-1:0] w_tbl_q;
    logic               w_flag_q;
    logic               w_tbl_we, w_tbl_re, w_flag_we, w_flag_re;
    logic [SW+SYM_W-1:0] w_tbl_waddr, w_tbl_raddr;
    logic [SW-1:0]      w_flag_waddr, w_flag_raddr;

    logic               w_accept, w_s1_adv, w_idx_ok;
    logic [STATE_W-1:0] w_cs_e, w_cs0;
    logic               w_dead_e, w_dead0, w_dead1;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= '0;
            r_count <= COUNT_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INITIAL_STATE: r_init  <= i_cfg_data[STATE_W-1:0];
                CFG_STATE_COUNT:   r_count <= i_cfg_data;
                default:           r_init  <= r_init;
            endcase
        end
    end

    // States in use, capped at the table size
    assign w_limit = (r_count > COUNT_W'(TABLE_STATES)) ? COUNT_W'(TABLE_STATES) : r_count;

    // Handshake: block only when both result stages are full and stalled
    assign w_s1_adv   = r_s1_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_s1_v || !r_out_v || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Settle the last lookup: read data is the new state
    assign w_cs_e   = r_lk ? w_tbl_q[STATE_W-1:0] : r_cur;
    assign w_dead_e = r_lk ? (!w_tbl_q[STATE_W] ||
                              ({1'b0, w_tbl_q[STATE_W-1:0]} >= w_limit))
                           : r_dead;

    // Start of text picks up the initial state
    assign w_cs0   = r_in_text ? w_cs_e : r_init;
    assign w_dead0 = r_in_text ? w_dead_e : 1'b0;
    assign w_dead1 = w_dead0 || ({1'b0, w_cs0} >= w_limit);

    assign w_idx_ok = {1'b0, i_in_req.state_index} < COUNT_W'(TABLE_STATES);

    // Memory accesses
    always_comb begin
        w_tbl_we     = w_accept && (i_in_req.command == CMD_WR_TRANS) && w_idx_ok;
        w_flag_we    = w_accept && (i_in_req.command == CMD_WR_FLAG) && w_idx_ok;
        w_tbl_re     = w_accept && (i_in_req.command == CMD_TEXT) && !w_dead1;
        w_flag_re    = w_accept && (i_in_req.command == CMD_END);
        w_tbl_waddr  = {i_in_req.state_index[SW-1:0], i_in_req.symbol};
        w_flag_waddr = i_in_req.state_index[SW-1:0];
        w_tbl_raddr  = {w_cs0[SW-1:0], i_in_req.symbol};
        w_flag_raddr = w_cs0[SW-1:0];
    end

    // Walk state next values
    always_comb begin
        n_cur     = w_cs_e;
        n_dead    = w_dead_e;
        n_in_text = r_in_text;
        n_lk      = 1'b0;
        if (w_accept) begin
            case (i_in_req.command)
                CMD_TEXT: begin
                    n_cur     = w_cs0;
                    n_dead    = w_dead1;
                    n_lk      = !w_dead1;
                    n_in_text = 1'b1;
                end
                CMD_END: begin
                    n_cur     = w_cs0;
                    n_dead    = w_dead1;
                    n_in_text = 1'b0;
                end
                default: begin
                    n_in_text = r_in_text;
                end
            endcase
        end
    end

    // Result pipeline next values
    always_comb begin
        n_s1_v    = r_s1_v && !w_s1_adv;
        n_s1_dead = r_s1_dead;
        n_out_v   = r_out_v && !i_out_ready;
        n_out     = r_out;
        if (w_s1_adv) begin
            n_out_v        = 1'b1;
            n_out.accepted = !r_s1_dead && w_flag_q;
            n_out.died     = r_s1_dead;
        end
        if (w_flag_re) begin
            n_s1_v    = 1'b1;
            n_s1_dead = w_dead1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_dead    <= 1'b0;
            r_in_text <= 1'b0;
            r_lk      <= 1'b0;
            r_s1_v    <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_cur     <= n_cur;
            r_dead    <= n_dead;
            r_in_text <= n_in_text;
            r_lk      <= n_lk;
            r_s1_v    <= n_s1_v;
            r_out_v   <= n_out_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_s1_dead <= n_s1_dead;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_res   = r_out;

    // Transition table: bit 8 valid, bits 7..0 next state
    dfatm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .i_clk     (i_clk),
        .i_wr_en   (w_tbl_we),
        .i_wr_addr (w_tbl_waddr),
        .i_wr_data ({i_in_req.next_valid, i_in_req.next_state}),
        .i_rd_en   (w_tbl_re),
        .i_rd_addr (w_tbl_raddr),
        .o_rd_data (w_tbl_q)
    );

    // Accepting flags
    dfatm_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_STATES)
    ) u_flags (
        .i_clk     (i_clk),
        .i_wr_en   (w_flag_we),
        .i_wr_addr (w_flag_waddr),
        .i_wr_data (i_in_req.accept_flag),
        .i_rd_en   (w_flag_re),
        .i_rd_addr (w_flag_raddr),
        .o_rd_data (w_flag_q)
    );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import dfatm_pkg::*;

    localparam int REQ_W        = $bits(t_in_req);
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 1000;
    localparam int ITEM_TARGET  = 360;
    localparam int TEXT_TARGET  = 40;

    typedef struct packed {
        t_cfg_idx   reg_index;
        logic [8:0] value;
    } t_cfg_wr;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_in_req  in_req    = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out_res out_res;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    t_cfg_wr  cfg_wr    = '0;

    // Requests and register writes waiting to go out, verdicts waiting to come back
    t_in_req  pending_reqs[$];
    t_cfg_wr  pending_cfg[$];
    t_out_res verdicts_due[$];

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    bit          calm           = 1'b0;

    // Predicted automaton: table, flags, registers and walk state
    bit [8:0] trans_mem [65536];
    bit       accept_mem [256];
    bit [7:0] init_reg  = '0;
    bit [8:0] count_reg = 9'd1;
    bit [7:0] cur_state = '0;
    bit       is_dead   = 1'b0;
    bit       in_text   = 1'b0;

    // Stimulus side view: states and bytes of the automaton built for this phase
    bit [7:0] live[$];
    bit [7:0] alpha[$];
    bit [7:0] gen_init   = '0;
    int       gen_limit  = 1;
    int       gen_items  = 0;
    int       gen_texts  = 0;

    dfa_table_matcher_unit #(
        .NUM_STATES (256)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_res   (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_wr.reg_index),
        .i_cfg_data  (cfg_wr.value)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the predicted automaton by one accepted request
    task automatic walk_dfa(input t_in_req r);
        int       limit;
        bit [8:0] entry;
        t_out_res v;
        limit = (count_reg > 9'd256) ? 256 : int'(count_reg);
        case (r.command)
            CMD_WR_TRANS: trans_mem[{r.state_index, r.symbol}] = {r.next_valid, r.next_state};
            CMD_WR_FLAG:  accept_mem[r.state_index] = r.accept_flag;
            default: begin
                if (!in_text) begin
                    cur_state = init_reg;
                    is_dead   = (cur_state >= limit);
                    in_text   = 1'b1;
                end
                if (cur_state >= limit)
                    is_dead = 1'b1;
                if (r.command == CMD_TEXT) begin
                    if (!is_dead) begin
                        entry = trans_mem[{cur_state, r.symbol}];
                        if (!entry[8]) begin
                            is_dead = 1'b1;
                        end else begin
                            cur_state = entry[7:0];
                            if (cur_state >= limit)
                                is_dead = 1'b1;
                        end
                    end
                end else begin
                    v.accepted = !is_dead && accept_mem[cur_state];
                    v.died     = is_dead;
                    verdicts_due.insert(verdicts_due.size(), v);
                    in_text = 1'b0;
                end
            end
        endcase
    endtask

    // Request driver: predicts on acceptance, then offers the next request
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            cur_state = '0;
            is_dead   = 1'b0;
            in_text   = 1'b0;
        end else begin
            if (in_valid && in_ready)
                walk_dfa(in_req);
            if (!in_valid || in_ready) begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
                    in_valid <= 1'b1;
                    in_req   <= pending_reqs.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Register write driver
    always @(posedge clk) begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
            init_reg  = '0;
            count_reg = 9'd1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_wr.reg_index == CFG_INITIAL_STATE)
                    init_reg = cfg_wr.value[7:0];
                else
                    count_reg = cfg_wr.value;
            end
            if (!cfg_valid || cfg_ready) begin
                if (pending_cfg.size() != 0) begin
                    cfg_valid <= 1'b1;
                    cfg_wr    <= pending_cfg.pop_front();
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Verdict monitor
    always @(posedge clk) begin : verdict_check
        t_out_res want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("verdict with no text ended: accepted %0b died %0b",
                           out_res.accepted, out_res.died);
                    mismatch_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (out_res.accepted !== want.accepted) begin
                        $error("accepted: expected %0b, got %0b", want.accepted, out_res.accepted);
                        mismatch_count++;
                    end
                    if (out_res.died !== want.died) begin
                        $error("died: expected %0b, got %0b", want.died, out_res.died);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 25);
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic bit holds(input bit [7:0] q[$], input bit [7:0] v);
        foreach (q[i])
            if (q[i] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit dead_start();
        return gen_init >= gen_limit;
    endfunction

    // Unused fields carry random bits
    function automatic t_in_req noise_req(input t_cmd c);
        t_in_req r;
        r = t_in_req'(REQ_W'($urandom));
        r.command = c;
        return r;
    endfunction

    task automatic queue_trans(input bit [7:0] st, input bit [7:0] sym,
                               input bit [7:0] nxt, input bit nv);
        t_in_req r;
        r = noise_req(CMD_WR_TRANS);
        r.state_index = st;
        r.symbol      = sym;
        r.next_state  = nxt;
        r.next_valid  = nv;
        pending_reqs.insert(pending_reqs.size(), r);
        gen_items++;
    endtask

    task automatic queue_flag(input bit [7:0] st, input bit af);
        t_in_req r;
        r = noise_req(CMD_WR_FLAG);
        r.state_index = st;
        r.accept_flag = af;
        pending_reqs.insert(pending_reqs.size(), r);
        gen_items++;
    endtask

    task automatic queue_byte(input bit [7:0] sym);
        t_in_req r;
        r = noise_req(CMD_TEXT);
        r.symbol = sym;
        pending_reqs.insert(pending_reqs.size(), r);
        gen_items++;
    endtask

    task automatic queue_end();
        pending_reqs.insert(pending_reqs.size(), noise_req(CMD_END));
        gen_items++;
        gen_texts++;
    endtask

    // Wait until every request has gone and every verdict is back, then let the pipe drain
    task automatic settle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || verdicts_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_cfg(input bit [8:0] init_data, input bit [8:0] count);
        settle();
        pending_cfg.insert(pending_cfg.size(),
                           t_cfg_wr'{reg_index: CFG_INITIAL_STATE, value: init_data});
        pending_cfg.insert(pending_cfg.size(),
                           t_cfg_wr'{reg_index: CFG_STATE_COUNT, value: count});
        do
            @(negedge clk);
        while (pending_cfg.size() != 0 || cfg_valid);
        gen_init  = init_data[7:0];
        gen_limit = (count > 9'd256) ? 256 : int'(count);
    endtask

    // Entry of a live state on a live byte: stays among live states, leaves the
    // states in use, or is invalid, so a walk never reads an unloaded entry
    task automatic write_live_entry(input bit [7:0] s, input bit [7:0] a);
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            queue_trans(s, a, live[$urandom_range(live.size() - 1)], 1'b1);
        else if (roll < 90 && gen_limit < 256)
            queue_trans(s, a, 8'($urandom_range(255, gen_limit)), 1'b1);
        else
            queue_trans(s, a, 8'($urandom), 1'b0);
    endtask

    // Small random automaton over a few bytes, initial state among its states unless it starts dead
    task automatic build_dfa();
        int       n_states;
        int       n_syms;
        bit [7:0] v;
        live.delete();
        alpha.delete();
        if (!dead_start())
            live.insert(live.size(), gen_init);
        n_states = $urandom_range(6, 2);
        while (live.size() < n_states && live.size() < gen_limit) begin
            v = 8'($urandom_range(gen_limit - 1));
            if (!holds(live, v))
                live.insert(live.size(), v);
        end
        n_syms = $urandom_range(4, 2);
        while (alpha.size() < n_syms) begin
            v = 8'($urandom);
            if (!holds(alpha, v))
                alpha.insert(alpha.size(), v);
        end
        foreach (live[i]) begin
            foreach (alpha[j])
                write_live_entry(live[i], alpha[j]);
            queue_flag(live[i], $urandom_range(99) < 60);
        end
    endtask

    // One text, with the odd table or flag write slipped in mid-text
    task automatic send_text(input int len, input bit hold);
        bit [7:0] sym;
        for (int i = 0; i < len; i++) begin
            if (hold && i == len / 2)
                settle();
            case ($urandom_range(19))
                0: if (live.size() != 0)
                    write_live_entry(live[$urandom_range(live.size() - 1)],
                                     alpha[$urandom_range(alpha.size() - 1)]);
                1: queue_flag(8'($urandom), 1'($urandom));
                2: begin
                    do
                        sym = 8'($urandom);
                    while (holds(alpha, sym));
                    queue_trans(8'($urandom), sym, 8'($urandom), 1'($urandom));
                end
                default: ;
            endcase
            sym = dead_start() ? 8'($urandom) : alpha[$urandom_range(alpha.size() - 1)];
            queue_byte(sym);
        end
        queue_end();
    endtask

    task automatic run_phase(input bit [8:0] init_data, input bit [8:0] count,
                             input int quota, input bit hold);
        int stop_at;
        int n;
        int len;
        apply_cfg(init_data, count);
        build_dfa();
        stop_at = gen_items + quota;
        n = 0;
        while (gen_items < stop_at) begin
            len = ($urandom_range(4) == 0) ? $urandom_range(1) : $urandom_range(10, 2);
            if (hold && n == 2)
                send_text(8, 1'b1);
            else
                send_text(len, 1'b0);
            n++;
        end
    endtask

    initial begin : stimulus
        bit [8:0] count;
        bit [8:0] init_data;
        int       lim;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: one live state under the reset registers
        queue_trans(8'h00, 8'h00, 8'h00, 1'b1);
        queue_trans(8'h00, 8'hFF, 8'hFF, 1'b0);
        queue_trans(8'h00, 8'h5A, 8'hFF, 1'b1);
        queue_flag(8'h00, 1'b1);
        queue_flag(8'hFF, 1'b0);
        queue_trans(8'hFF, 8'hA5, 8'h00, 1'b1);
        // empty text judged on the initial state
        queue_end();
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_end();
        // invalid entry, then a byte that the dead walk must ignore
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_end();
        // walk to a state outside those in use
        queue_byte(8'h5A);
        queue_end();
        // writes in the middle of a text take effect at once
        queue_byte(8'h00);
        queue_flag(8'h00, 1'b0);
        queue_end();
        queue_flag(8'h00, 1'b1);
        queue_byte(8'h00);
        queue_trans(8'h00, 8'h00, 8'h00, 1'b0);
        queue_byte(8'h00);
        queue_end();
        queue_trans(8'h00, 8'h00, 8'h00, 1'b1);
        queue_end();

        // Register extremes and the dead-start cases
        run_phase(9'h0FF, 9'd256, 40, 1'b0);
        run_phase(9'd200, 9'd100, 20, 1'b0);
        run_phase(9'($urandom), 9'd0, 15, 1'b0);
        run_phase(9'h100, 9'd511, 50, 1'b1);

        // A stretch with neither side idling
        calm = 1'b1;
        run_phase({1'($urandom), 8'($urandom_range(63))}, 9'd64, 60, 1'b0);
        settle();
        calm = 1'b0;

        // Random settings, mostly with the walk starting inside the states in use
        while (gen_items < ITEM_TARGET || gen_texts < TEXT_TARGET) begin
            count = ($urandom_range(1) != 0) ? 9'($urandom_range(8, 1))
                                             : 9'($urandom_range(300, 9));
            lim = (count > 9'd256) ? 256 : int'(count);
            if ($urandom_range(9) != 0)
                init_data = {1'($urandom), 8'($urandom_range(lim - 1))};
            else
                init_data = 9'($urandom);
            run_phase(init_data, count, 60, 1'b0);
        end

        settle();
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/dfatm_pkg.sv
rtl/dfatm_ram.sv
rtl/dfa_table_matcher_unit.sv
bench/tb_top.sv
